[hw/rtl/servo_bus_packet_framer_assert.svh]
// Assertion macros shared by the framer modules.
`ifndef SERVO_BUS_PACKET_FRAMER_ASSERT_SVH
`define SERVO_BUS_PACKET_FRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SBPF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("servo bus framer assertion failed");
`define SBPF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("servo bus framer assertion failed");
`else
`define SBPF_ASSERT(label, prop)
`define SBPF_ASSERT_ALWAYS(label, prop)
`endif

`endif

[hw/rtl/sbpf_pkg.sv]
`timescale 1ns / 1ps

package sbpf_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE_GOAL = 2'd0,
    REQ_READ_POS   = 2'd1,
    REQ_TORQUE     = 2'd2,
    REQ_RX_BYTE    = 2'd3
  } req_e;

  typedef enum logic {
    KIND_TX    = 1'b0,
    KIND_REPLY = 1'b1
  } kind_e;

  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] INS_READ     = 8'h02;
  localparam logic [7:0] INS_WRITE    = 8'h03;
  localparam logic [7:0] ADR_TORQUE   = 8'h28;
  localparam logic [7:0] ADR_GOAL     = 8'h2A;
  localparam logic [7:0] ADR_PRESENT  = 8'h38;
  localparam logic [7:0] READ_LEN     = 8'h02;
  localparam logic [7:0] LEN_LONG     = 8'h05;
  localparam logic [7:0] LEN_SHORT    = 8'h04;

  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] LAST_IDX_LONG  = 4'd8;
  localparam logic [IdxW-1:0] LAST_IDX_SHORT = 4'd7;

  localparam int unsigned CntW = 3;
  localparam logic [CntW-1:0] RX_CNT_LAST = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_enc_t;

  typedef struct packed {
    logic       arm;
    logic       step;
    logic [7:0] id;
    logic [7:0] data;
  } rx_cmd_t;

  typedef struct packed {
    logic        hit;
    logic        status;
    logic [15:0] position;
  } rx_res_t;

endpackage

[hw/rtl/sbpf_tx_enc.sv]
`timescale 1ns / 1ps

module sbpf_tx_enc (
  input  sbpf_pkg::req_e                  req_type_i,
  input  logic [7:0]                      servo_id_i,
  input  logic [15:0]                     goal_pos_i,
  input  logic                            torque_on_i,
  input  logic [sbpf_pkg::IdxW-1:0]       idx_i,
  output sbpf_pkg::tx_enc_t               enc_o
);
  import sbpf_pkg::*;

  logic            is_long;
  logic [7:0]      len;
  logic [7:0]      ins;
  logic [7:0]      adr;
  logic [7:0]      prm1;
  logic [7:0]      prm2;
  logic [7:0]      sum;
  logic [7:0]      chk;
  logic [IdxW-1:0] last_idx;

  always_comb begin
    is_long  = (req_type_i == REQ_WRITE_GOAL);
    len      = is_long ? LEN_LONG : LEN_SHORT;
    ins      = (req_type_i == REQ_READ_POS) ? INS_READ : INS_WRITE;
    prm2     = is_long ? goal_pos_i[15:8] : 8'h00;
    case (req_type_i)
      REQ_WRITE_GOAL: begin
        adr  = ADR_GOAL;
        prm1 = goal_pos_i[7:0];
      end
      REQ_READ_POS: begin
        adr  = ADR_PRESENT;
        prm1 = READ_LEN;
      end
      default: begin
        adr  = ADR_TORQUE;
        prm1 = {7'd0, torque_on_i};
      end
    endcase
    sum      = servo_id_i + len + ins + adr + prm1 + prm2;
    chk      = ~sum;
    last_idx = is_long ? LAST_IDX_LONG : LAST_IDX_SHORT;

    case (idx_i) inside
      4'd0, 4'd1: enc_o.data = HDR_BYTE;
      4'd2:       enc_o.data = servo_id_i;
      4'd3:       enc_o.data = len;
      4'd4:       enc_o.data = ins;
      4'd5:       enc_o.data = adr;
      4'd6:       enc_o.data = prm1;
      4'd7:       enc_o.data = is_long ? prm2 : chk;
      default:    enc_o.data = chk;
    endcase
    enc_o.last = (idx_i == last_idx);
  end

endmodule

[hw/rtl/sbpf_rx.sv]
`timescale 1ns / 1ps
`include "servo_bus_packet_framer_assert.svh"

module sbpf_rx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbpf_pkg::rx_cmd_t cmd_i,
  output sbpf_pkg::rx_res_t res_o
);
  import sbpf_pkg::*;

  logic            armed_q, armed_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      exp_id_q, exp_id_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [7:0]      pos_lo_q, pos_lo_d;
  logic [7:0]      pos_hi_q, pos_hi_d;

  always_comb begin
    res_o.hit      = armed_q && (cnt_q == RX_CNT_LAST);
    res_o.status   = !hdr_ok_q;
    res_o.position = hdr_ok_q ? {pos_hi_q, pos_lo_q} : 16'd0;
  end

  always_comb begin
    armed_d  = armed_q;
    cnt_d    = cnt_q;
    exp_id_d = exp_id_q;
    hdr_ok_d = hdr_ok_q;
    pos_lo_d = pos_lo_q;
    pos_hi_d = pos_hi_q;
    if (cmd_i.arm) begin
      armed_d  = 1'b1;
      cnt_d    = '0;
      exp_id_d = cmd_i.id;
      hdr_ok_d = 1'b1;
    end else if (cmd_i.step && armed_q) begin
      case (cnt_q) inside
        3'd0, 3'd1: if (cmd_i.data != HDR_BYTE) hdr_ok_d = 1'b0;
        3'd2:       if (cmd_i.data != exp_id_q) hdr_ok_d = 1'b0;
        3'd5:       pos_lo_d = cmd_i.data;
        3'd6:       pos_hi_d = cmd_i.data;
        default:    ;
      endcase
      if (cnt_q == RX_CNT_LAST) begin
        armed_d = 1'b0;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b0;
      cnt_q    <= '0;
      exp_id_q <= 8'd0;
      hdr_ok_q <= 1'b1;
      pos_lo_q <= 8'd0;
      pos_hi_q <= 8'd0;
    end else begin
      armed_q  <= armed_d;
      cnt_q    <= cnt_d;
      exp_id_q <= exp_id_d;
      hdr_ok_q <= hdr_ok_d;
      pos_lo_q <= pos_lo_d;
      pos_hi_q <= pos_hi_d;
    end
  end

  `SBPF_ASSERT(a_idle_count_zero, !armed_q |-> cnt_q == '0)
  `SBPF_ASSERT(a_arm_restarts, cmd_i.arm |=> armed_q && cnt_q == '0 && hdr_ok_q)
  `SBPF_ASSERT(a_hit_disarms, cmd_i.step && !cmd_i.arm && res_o.hit |=> !armed_q)

endmodule

[hw/rtl/servo_bus_packet_framer.sv]
`timescale 1ns / 1ps
`include "servo_bus_packet_framer_assert.svh"
// Servo bus packet framer.
// The input channel takes one request per transfer: a write goal position,
// a read position request or a torque enable produce a complete bus packet,
// and a received bus byte feeds the reply receiver. The output channel
// carries transmit bytes (last_byte_o marks the checksum byte) and, on the
// eighth reply byte after a read request, one reply result.
// A request is held in an input register and its bytes are built there by
// a small encoder, one byte per cycle into the output register unless the
// output stalls. A write goal packet has nine bytes, a read or torque packet
// eight. The next request is accepted in the cycle that issues the last
// byte of the current one, so packets follow each other without gaps.
// Each result is built from the input register into the output register.
// When the receiver asserts out_stall_i the output register holds its byte
// and the input side stalls once the input register is full; a received byte
// that gives no result still drains while the output is stalled.
// Reset clears the valid bits of both registers and disarms the receiver.

module servo_bus_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  servo_id_i,
  input  logic [15:0] goal_pos_i,
  input  logic        torque_on_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o,
  output logic        reply_status_o,
  output logic [15:0] position_o
);
  import sbpf_pkg::*;

  logic            cmd_vld_q, cmd_vld_d;
  logic [IdxW-1:0] idx_q, idx_d;
  req_e            type_q, type_d;
  logic [7:0]      id_q, id_d;
  logic [15:0]     goal_q, goal_d;
  logic            ton_q, ton_d;
  logic [7:0]      rxb_q, rxb_d;

  logic            out_vld_q, out_vld_d;
  kind_e           kind_q, kind_d;
  logic [7:0]      txb_q, txb_d;
  logic            last_q, last_d;
  logic            status_q, status_d;
  logic [15:0]     pos_q, pos_d;

  tx_enc_t         enc;
  rx_cmd_t         rx_cmd;
  rx_res_t         rx_res;

  logic            accept;
  logic            is_rx;
  logic            load_ok;
  logic            fire;
  logic            item_done;
  logic            emit;

  sbpf_tx_enc u_enc (
    .req_type_i  (type_q),
    .servo_id_i  (id_q),
    .goal_pos_i  (goal_q),
    .torque_on_i (ton_q),
    .idx_i       (idx_q),
    .enc_o       (enc)
  );

  sbpf_rx u_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rx_cmd),
    .res_o  (rx_res)
  );

  always_comb begin
    is_rx      = (type_q == REQ_RX_BYTE);
    load_ok    = !out_vld_q || !out_stall_i;
    fire       = cmd_vld_q && (load_ok || (is_rx && !rx_res.hit));
    item_done  = fire && (is_rx || enc.last);
    emit       = fire && (!is_rx || rx_res.hit);
    in_stall_o = cmd_vld_q && !item_done;
    accept     = in_valid_i && !in_stall_o;

    rx_cmd.arm  = item_done && (type_q == REQ_READ_POS);
    rx_cmd.step = fire && is_rx;
    rx_cmd.id   = id_q;
    rx_cmd.data = rxb_q;
  end

  always_comb begin
    cmd_vld_d = cmd_vld_q;
    idx_d     = idx_q;
    type_d    = type_q;
    id_d      = id_q;
    goal_d    = goal_q;
    ton_d     = ton_q;
    rxb_d     = rxb_q;
    if (accept) begin
      cmd_vld_d = 1'b1;
      idx_d     = '0;
      type_d    = req_e'(req_type_i);
      id_d      = servo_id_i;
      goal_d    = goal_pos_i;
      ton_d     = torque_on_i;
      rxb_d     = rx_byte_i;
    end else if (item_done) begin
      cmd_vld_d = 1'b0;
    end else if (fire) begin
      idx_d = idx_q + {{(IdxW-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    kind_d    = kind_q;
    txb_d     = txb_q;
    last_d    = last_q;
    status_d  = status_q;
    pos_d     = pos_q;
    if (emit) begin
      out_vld_d = 1'b1;
      kind_d    = is_rx ? KIND_REPLY : KIND_TX;
      txb_d     = is_rx ? 8'd0 : enc.data;
      last_d    = is_rx ? 1'b0 : enc.last;
      status_d  = is_rx ? rx_res.status : 1'b0;
      pos_d     = is_rx ? rx_res.position : 16'd0;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    id_q     <= id_d;
    goal_q   <= goal_d;
    ton_q    <= ton_d;
    rxb_q    <= rxb_d;
    kind_q   <= kind_d;
    txb_q    <= txb_d;
    last_q   <= last_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign out_valid_o    = out_vld_q;
  assign out_kind_o     = kind_q;
  assign tx_byte_o      = txb_q;
  assign last_byte_o    = last_q;
  assign reply_status_o = status_q;
  assign position_o     = pos_q;

  `SBPF_ASSERT(a_idx_in_range, cmd_vld_q && !is_rx |-> idx_q <= LAST_IDX_LONG)
  `SBPF_ASSERT(a_first_byte_hdr, emit && !is_rx && idx_q == '0 |=> tx_byte_o == HDR_BYTE)
  `SBPF_ASSERT(a_reply_fields, out_vld_q && kind_q == KIND_REPLY |-> !last_q && txb_q == 8'd0)
  `SBPF_ASSERT(a_bad_reply_pos, out_vld_q && status_q |-> pos_q == 16'd0)
  `SBPF_ASSERT(a_emit_has_slot, emit |-> load_ok)

endmodule
